// ===== hw/rtl/mchv_pkg.sv =====
// Shared types and constants for the media chunk header validator.
// Word structs for the byte and result channels, register indexes, verdict codes.
// No dependencies.
package mchv_pkg;

   // Record header length in bytes (fixed by the stream format)
   localparam int HEADER_BYTES = 16;
   // Width of the chunk length arithmetic (covers the largest chunk size)
   localparam int TOTAL_W      = 22;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WRONG_AUDIO_TYPE = 1'b0,
      CSR_AUDIO_CHECK_EN   = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      VERDICT_OK          = 3'd0,
      VERDICT_BAD_MARK    = 3'd1,
      VERDICT_TOO_MANY    = 3'd2,
      VERDICT_NONE        = 3'd3,
      VERDICT_TOO_BIG     = 3'd4,
      VERDICT_TOO_SMALL   = 3'd5,
      VERDICT_BAD_TYPE    = 3'd6,
      VERDICT_WRONG_AUDIO = 3'd7
   } verdict_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       chunk_first;
   } req_word_type;

   typedef struct packed {
      logic        result_kind;
      logic [19:0] record_size;
      logic [11:0] record_type;
      logic        is_extended;
      logic [7:0]  ext_first;
      logic [7:0]  ext_second;
      logic [2:0]  verdict;
      logic        seq_given;
      logic [14:0] seq_start_index;
      logic [15:0] record_count;
      logic [17:0] total_size;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic [11:0] wrong_audio_type;
      logic        audio_check_enable;
   } cfg_type;

endpackage

// ===== hw/rtl/media_chunk_header_validator_top.sv =====
// Top level of the media chunk header validator: configuration registers,
// byte channel, result register. Depends on mchv_pkg and mchv_parse.
//
// Usage:
//  - req_*: one chunk byte per word; chunk_first marks byte 0 of a chunk and
//    restarts the parse, dropping any chunk in progress without a verdict.
//  - rsp_*: a record word after byte 3 of every record header, and one
//    verdict word (last = 1) after the chunk header fails or the final record
//    header ends. Payload bytes and bytes after the verdict give nothing.
//  - csr_*: register writes, always ready; write only while the block is idle.
// Timing: one byte per cycle sustained unless req_stall is raised. A result shows
// on rsp in the cycle after the byte that causes it is taken; the parse is one
// pass of logic between the parse state and the result register.
// Stall: while a result waits under rsp_stall, req_stall is raised and the
// result word holds. An empty or draining result register lets bytes flow.
// Reset: parse waits for a chunk start, registers read zero, rsp is empty.
module media_chunk_header_validator_top import mchv_pkg::*; #(
   parameter int CHUNK_BYTES      = 131072,
   parameter int MAX_RECORD_COUNT = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_data_ff;
   logic         accept;
   logic         res_valid;
   rsp_word_type res_word;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_WRONG_AUDIO_TYPE: cfg_ff.wrong_audio_type   <= csr_wdata;
            CSR_AUDIO_CHECK_EN:   cfg_ff.audio_check_enable <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   mchv_parse #(
      .CHUNK_BYTES      (CHUNK_BYTES),
      .MAX_RECORD_COUNT (MAX_RECORD_COUNT)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_word   (req_data),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   // Load a new result or drop the one taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res_word;
      end
   end

endmodule

// ===== hw/rtl/mchv_parse.sv =====
// Byte-wise chunk header parser: holds the parse state and forms one result
// word per accepted byte where the format calls for one.
// Depends on mchv_pkg.
module mchv_parse import mchv_pkg::*; #(
   parameter int CHUNK_BYTES      = 131072,
   parameter int MAX_RECORD_COUNT = 2048
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_word_type in_word,
   input  cfg_type      cfg,
   output logic         res_valid,
   output rsp_word_type res_word
);

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_CHDR = 2'd1,
      PH_RECS = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   localparam logic [17:0]        SUM_MAX   = 18'h3ffff;
   localparam logic [14:0]        SEQ_NONE  = 15'h7fff;
   localparam logic [3:0]         EXT_MARK  = 4'h8;
   localparam logic [3:0]         IDX_LAST  = 4'(HEADER_BYTES - 1);
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(CHUNK_BYTES);
   localparam logic [TOTAL_W-1:0] TOTAL_MIN = TOTAL_W'(CHUNK_BYTES / 10);
   localparam logic [15:0]        COUNT_MAX = 16'(MAX_RECORD_COUNT);

   function automatic logic type_known(input logic [11:0] t);
      logic k;
      case (t)
         12'h000, 12'h2c0, 12'h3c0, 12'h4c0, 12'h9c0,
         12'h2e0, 12'h6e0, 12'h7e0, 12'h8e0, 12'hae0,
         12'hbe0, 12'hce0,
         12'he01, 12'he02, 12'he03, 12'he04, 12'he05, 12'he06: k = 1'b1;
         default: k = 1'b0;
      endcase
      return k;
   endfunction

   phase_type   phase_ff,   phase_in;
   logic [3:0]  idx_ff,     idx_in;
   logic [23:0] held_ff,    held_in;
   logic [15:0] count_ff,   count_in;
   logic [15:0] seq_ff,     seq_in;
   logic [15:0] recs_ff,    recs_in;
   logic [17:0] sum_ff,     sum_in;
   logic        bad_ff,     bad_in;
   logic        audio_ff,   audio_in;

   // Effective state after an optional chunk restart
   phase_type   ph_cur;
   logic [3:0]  idx_cur;
   logic [15:0] count_cur, seq_cur, recs_cur;
   logic [17:0] sum_cur;
   logic        bad_cur, audio_cur;

   logic [7:0]  db, b0, b1, b2;
   logic [11:0] rec_type;
   logic [19:0] rec_size;
   logic        rec_ext;
   logic [20:0] sum_wide;
   logic [TOTAL_W-1:0] total;
   logic [2:0]  early_v;
   logic [2:0]  final_v;
   logic        emit_rec, emit_verdict;
   logic [2:0]  verdict_v;

   always_comb begin
      db = in_word.data_byte;
      if (in_word.chunk_first) begin
         ph_cur    = PH_CHDR;
         idx_cur   = '0;
         count_cur = '0;
         seq_cur   = '0;
         recs_cur  = '0;
         sum_cur   = '0;
         bad_cur   = 1'b0;
         audio_cur = 1'b0;
      end else begin
         ph_cur    = phase_ff;
         idx_cur   = idx_ff;
         count_cur = count_ff;
         seq_cur   = seq_ff;
         recs_cur  = recs_ff;
         sum_cur   = sum_ff;
         bad_cur   = bad_ff;
         audio_cur = audio_ff;
      end

      // Decode the record header from the three held bytes and this one
      b0       = held_ff[23:16];
      b1       = held_ff[15:8];
      b2       = held_ff[7:0];
      rec_type = {b2[3:0], db};
      rec_ext  = (b0[7:4] == EXT_MARK);
      rec_size = rec_ext ? 20'd0 : {b0, b1, b2[7:4]};
      sum_wide = {3'b000, sum_cur} + {1'b0, rec_size};

      // Chunk header checks on its last byte
      if (!db[7]) begin
         early_v = VERDICT_BAD_MARK;
      end else if (count_cur > COUNT_MAX) begin
         early_v = VERDICT_TOO_MANY;
      end else if (count_cur == 16'd0) begin
         early_v = VERDICT_NONE;
      end else begin
         early_v = VERDICT_OK;
      end

      // Defaults: hold
      phase_in     = ph_cur;
      idx_in       = idx_cur;
      held_in      = held_ff;
      count_in     = count_cur;
      seq_in       = seq_cur;
      recs_in      = recs_cur;
      sum_in       = sum_cur;
      bad_in       = bad_cur;
      audio_in     = audio_cur;
      emit_rec     = 1'b0;
      emit_verdict = 1'b0;
      verdict_v    = VERDICT_OK;

      case (ph_cur)
         PH_CHDR: begin
            case (idx_cur)
               4'd0: count_in = {8'd0, db};
               4'd1: count_in = {db, count_cur[7:0]};
               4'd2: seq_in   = {8'd0, db};
               default: seq_in = {db, seq_cur[7:0]};
            endcase
            if (idx_cur == 4'd3) begin
               idx_in = '0;
               if (early_v != VERDICT_OK) begin
                  emit_verdict = 1'b1;
                  verdict_v    = early_v;
                  phase_in     = PH_DONE;
               end else begin
                  phase_in = PH_RECS;
               end
            end else begin
               idx_in = idx_cur + 4'd1;
            end
         end
         PH_RECS: begin
            // Shift in the first three header bytes
            if (idx_cur == 4'd0) begin
               held_in = {16'd0, db};
            end else if (idx_cur < 4'd3) begin
               held_in = {held_ff[15:0], db};
            end
            if (idx_cur == 4'd3) begin
               emit_rec = 1'b1;
               sum_in   = (sum_wide > {3'b000, SUM_MAX}) ? SUM_MAX : sum_wide[17:0];
               if (!type_known(rec_type)) bad_in = 1'b1;
               if (rec_type == cfg.wrong_audio_type) audio_in = 1'b1;
            end
            if (idx_cur >= IDX_LAST) begin
               idx_in  = '0;
               recs_in = recs_cur + 16'd1;
               if (recs_in == count_cur) begin
                  emit_verdict = 1'b1;
                  verdict_v    = final_v;
                  phase_in     = PH_DONE;
               end
            end else begin
               idx_in = idx_cur + 4'd1;
            end
         end
         default: ;
      endcase
   end

   // Final chunk verdict from the size total and the type flags
   always_comb begin
      total = TOTAL_W'(sum_cur) + TOTAL_W'({count_cur, 4'd0}) + TOTAL_W'(4);
      if (total > TOTAL_MAX) begin
         final_v = VERDICT_TOO_BIG;
      end else if (total < TOTAL_MIN) begin
         final_v = VERDICT_TOO_SMALL;
      end else if (bad_cur) begin
         final_v = VERDICT_BAD_TYPE;
      end else if (cfg.audio_check_enable && audio_cur) begin
         final_v = VERDICT_WRONG_AUDIO;
      end else begin
         final_v = VERDICT_OK;
      end
   end

   // Form the result word
   always_comb begin
      res_word  = '0;
      res_valid = accept && (emit_rec || emit_verdict);
      if (emit_verdict) begin
         res_word.result_kind  = 1'b1;
         res_word.verdict      = verdict_v;
         res_word.record_count = count_in;
         res_word.total_size   = sum_in;
         res_word.last         = 1'b1;
         if (verdict_v != VERDICT_BAD_MARK && seq_in[14:0] != SEQ_NONE) begin
            res_word.seq_given       = 1'b1;
            res_word.seq_start_index = seq_in[14:0];
         end
      end else begin
         res_word.record_size = rec_size;
         res_word.record_type = rec_type;
         res_word.is_extended = rec_ext;
         if (rec_ext) begin
            res_word.ext_first  = {b0[3:0], b1[7:4]};
            res_word.ext_second = {b1[3:0], b2[7:4]};
         end
      end
   end

   // Advance parse state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         idx_ff   <= '0;
         held_ff  <= '0;
         count_ff <= '0;
         seq_ff   <= '0;
         recs_ff  <= '0;
         sum_ff   <= '0;
         bad_ff   <= 1'b0;
         audio_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         held_ff  <= held_in;
         count_ff <= count_in;
         seq_ff   <= seq_in;
         recs_ff  <= recs_in;
         sum_ff   <= sum_in;
         bad_ff   <= bad_in;
         audio_ff <= audio_in;
      end
   end

endmodule
